@@ hw/rtl/tdts_pkg.sv @@
package tdts_pkg;

   localparam int MAX_LEXEME = 32;
   localparam int CH_W = 8;
   localparam int TOK_W = 4;
   localparam int LEN_W = 6;
   localparam int VAL_W = 31;
   localparam logic [VAL_W-1:0] VALUE_MAX = {VAL_W{1'b1}};

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W = 2;
   localparam int QCNT_W = 3;
   localparam logic [QCNT_W-1:0] QUEUE_ROOM_MAX = QCNT_W'(QUEUE_DEPTH - 2);

   typedef enum logic [TOK_W-1:0] {
      TOK_IDENT     = 4'd0,
      TOK_CONST     = 4'd1,
      TOK_PLUS      = 4'd2,
      TOK_MINUS     = 4'd3,
      TOK_LPAREN    = 4'd4,
      TOK_RPAREN    = 4'd5,
      TOK_COMMA     = 4'd6,
      TOK_SEMICOLON = 4'd7,
      TOK_ASSIGN    = 4'd8,
      TOK_END       = 4'd9,
      TOK_ERROR     = 4'd10,
      TOK_TIMES     = 4'd11,
      TOK_DIVIDE    = 4'd12
   } token_type;

   typedef enum logic [3:0] {
      CLS_LETTER    = 4'd0,
      CLS_DIGIT     = 4'd1,
      CLS_PLUS      = 4'd2,
      CLS_MINUS     = 4'd3,
      CLS_LPAREN    = 4'd4,
      CLS_RPAREN    = 4'd5,
      CLS_COMMA     = 4'd6,
      CLS_SEMICOLON = 4'd7,
      CLS_COLON     = 4'd8,
      CLS_EQUAL     = 4'd9,
      CLS_END       = 4'd10,
      CLS_BLANK     = 4'd11,
      CLS_TIMES     = 4'd12,
      CLS_DIVIDE    = 4'd13,
      CLS_OTHER     = 4'd14
   } class_type;

   typedef enum logic [3:0] {
      ST_START = 4'b0001,
      ST_IDENT = 4'b0010,
      ST_CONST = 4'b0100,
      ST_COLON = 4'b1000
   } dfa_type;

   typedef struct packed {
      token_type        token;
      logic [LEN_W-1:0] length;
      logic [VAL_W-1:0] value;
      logic             last;
   } result_type;

   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } push_type;

   function automatic class_type classify(input logic [CH_W-1:0] ch, input logic eoi);
      class_type cls;
      if (eoi) begin
         cls = CLS_END;
      end else if ((ch inside {[8'h41:8'h5A]}) || (ch inside {[8'h61:8'h7A]})) begin
         cls = CLS_LETTER;
      end else if (ch inside {[8'h30:8'h39]}) begin
         cls = CLS_DIGIT;
      end else begin
         case (ch)
            8'h2B: cls = CLS_PLUS;
            8'h2D: cls = CLS_MINUS;
            8'h28: cls = CLS_LPAREN;
            8'h29: cls = CLS_RPAREN;
            8'h2C: cls = CLS_COMMA;
            8'h3B: cls = CLS_SEMICOLON;
            8'h3A: cls = CLS_COLON;
            8'h3D: cls = CLS_EQUAL;
            8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D: cls = CLS_BLANK;
            8'h2A: cls = CLS_TIMES;
            8'h2F: cls = CLS_DIVIDE;
            default: cls = CLS_OTHER;
         endcase
      end
      return cls;
   endfunction

endpackage

@@ hw/rtl/tdts_req_if.sv @@
interface tdts_req_if;
   logic                     valid;
   logic                     ready;
   logic [tdts_pkg::CH_W-1:0] ch;
   logic                     end_of_input;

   modport source(output valid, output ch, output end_of_input, input ready);
   modport sink(input valid, input ch, input end_of_input, output ready);
endinterface

@@ hw/rtl/tdts_rsp_if.sv @@
interface tdts_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [tdts_pkg::TOK_W-1:0] token;
   logic [tdts_pkg::LEN_W-1:0] lexeme_length;
   logic [tdts_pkg::VAL_W-1:0] constant_value;
   logic                       last;

   modport source(output valid, output token, output lexeme_length, output constant_value,
                  output last, input ready);
   modport sink(input valid, input token, input lexeme_length, input constant_value,
                input last, output ready);
endinterface

@@ hw/rtl/tdts_lexer.sv @@
module tdts_lexer (
   input  logic               clock,
   input  logic               reset,
   tdts_req_if.sink           req_if,
   output tdts_pkg::push_type push,
   input  logic               room
);
   import tdts_pkg::*;

   logic             in_valid_ff;
   logic [CH_W-1:0]  in_ch_ff;
   logic             in_eoi_ff;
   dfa_type          state_ff, state_in;
   logic [LEN_W-1:0] count_ff, count_in;
   logic [VAL_W-1:0] accum_ff, accum_in;

   logic             fire;
   class_type        cls;
   logic [3:0]       digit;
   logic [LEN_W-1:0] count_inc;
   logic [VAL_W+3:0] accum_prod;
   logic [VAL_W-1:0] accum_sat;
   logic             is_word;
   logic             start_phase;
   logic             emit_a, emit_b;
   token_type        a_tok, b_tok;
   logic [LEN_W-1:0] b_len;
   result_type       res_a, res_b;

   function automatic token_type single_token(input class_type c);
      token_type t;
      case (c)
         CLS_PLUS:      t = TOK_PLUS;
         CLS_MINUS:     t = TOK_MINUS;
         CLS_LPAREN:    t = TOK_LPAREN;
         CLS_RPAREN:    t = TOK_RPAREN;
         CLS_COMMA:     t = TOK_COMMA;
         CLS_SEMICOLON: t = TOK_SEMICOLON;
         CLS_END:       t = TOK_END;
         CLS_TIMES:     t = TOK_TIMES;
         CLS_DIVIDE:    t = TOK_DIVIDE;
         default:       t = TOK_ERROR;
      endcase
      return t;
   endfunction

   assign fire = in_valid_ff && room;
   assign req_if.ready = !in_valid_ff || fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_if.ready) begin
         in_valid_ff <= req_if.valid;
      end
      if (req_if.ready && req_if.valid) begin
         in_ch_ff  <= req_if.ch;
         in_eoi_ff <= req_if.end_of_input;
      end
   end

   assign cls   = classify(in_ch_ff, in_eoi_ff);
   // ASCII digits sit at 0x30..0x39, so the low nibble is the digit value
   assign digit = in_ch_ff[3:0];
   assign count_inc = (count_ff < LEN_W'(MAX_LEXEME)) ? count_ff + LEN_W'(1) : count_ff;
   assign accum_prod = ({4'b0, accum_ff} << 3) + ({4'b0, accum_ff} << 1) + (VAL_W+4)'(digit);
   assign accum_sat = (accum_prod > (VAL_W+4)'(VALUE_MAX)) ? VALUE_MAX : accum_prod[VAL_W-1:0];
   assign is_word = (cls == CLS_LETTER) || (cls == CLS_DIGIT);

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      accum_in    = accum_ff;
      start_phase = 1'b0;
      emit_a      = 1'b0;
      emit_b      = 1'b0;
      a_tok       = TOK_IDENT;
      b_tok       = TOK_ERROR;
      b_len       = LEN_W'(1);

      case (state_ff)
         ST_START: begin
            start_phase = 1'b1;
         end
         ST_IDENT: begin
            if (is_word) begin
               count_in = count_inc;
            end else begin
               emit_a      = 1'b1;
               a_tok       = TOK_IDENT;
               start_phase = (cls != CLS_BLANK);
            end
         end
         ST_CONST: begin
            if (cls == CLS_DIGIT) begin
               count_in = count_inc;
               accum_in = accum_sat;
            end else begin
               emit_a      = 1'b1;
               a_tok       = TOK_CONST;
               start_phase = (cls != CLS_BLANK);
            end
         end
         ST_COLON: begin
            // consume the follower; a blank is not counted
            emit_b   = 1'b1;
            b_tok    = (cls == CLS_EQUAL) ? TOK_ASSIGN : TOK_ERROR;
            b_len    = (cls == CLS_BLANK) ? count_ff : count_inc;
            state_in = ST_START;
            count_in = '0;
            accum_in = '0;
         end
         default: begin
            state_in = ST_START;
            count_in = '0;
            accum_in = '0;
         end
      endcase

      if (emit_a) begin
         state_in = ST_START;
         count_in = '0;
         accum_in = '0;
      end

      // reprocess the closing character from the start state
      if (start_phase) begin
         case (cls)
            CLS_LETTER: begin
               state_in = ST_IDENT;
               count_in = LEN_W'(1);
            end
            CLS_DIGIT: begin
               state_in = ST_CONST;
               count_in = LEN_W'(1);
               accum_in = VAL_W'(digit);
            end
            CLS_COLON: begin
               state_in = ST_COLON;
               count_in = LEN_W'(1);
            end
            CLS_BLANK: begin
               state_in = ST_START;
            end
            default: begin
               emit_b   = 1'b1;
               b_tok    = single_token(cls);
               b_len    = LEN_W'(1);
               state_in = ST_START;
               count_in = '0;
               accum_in = '0;
            end
         endcase
      end
   end

   always_comb begin
      res_a.token  = a_tok;
      res_a.length = count_ff;
      res_a.value  = (a_tok == TOK_CONST) ? accum_ff : '0;
      res_a.last   = !emit_b;
      res_b.token  = b_tok;
      res_b.length = b_len;
      res_b.value  = '0;
      res_b.last   = 1'b1;
      push.count   = fire ? ({1'b0, emit_a} + {1'b0, emit_b}) : 2'd0;
      push.first   = emit_a ? res_a : res_b;
      push.second  = res_b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_START;
         count_ff <= '0;
         accum_ff <= '0;
      end else if (fire) begin
         state_ff <= state_in;
         count_ff <= count_in;
         accum_ff <= accum_in;
      end
   end

   a_count_sat: assert property (@(posedge clock) disable iff (reset)
      count_ff <= LEN_W'(MAX_LEXEME))
      else $error("lexeme count above saturation limit");

   a_accum_const: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_CONST) |-> (accum_ff == '0))
      else $error("constant accumulator live outside a constant");

   a_two_close: assert property (@(posedge clock) disable iff (reset)
      (push.count == 2'd2) |->
         ((push.first.token == TOK_IDENT) || (push.first.token == TOK_CONST)))
      else $error("two tokens without an identifier or constant closing");

endmodule

@@ hw/rtl/tdts_result_queue.sv @@
module tdts_result_queue (
   input  logic               clock,
   input  logic               reset,
   input  tdts_pkg::push_type push,
   output logic               room,
   tdts_rsp_if.source         rsp_if
);
   import tdts_pkg::*;

   result_type        entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] head_ff, head_in;
   logic [QPTR_W-1:0] tail_ff, tail_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              pop;
   result_type        head_entry;

   assign room = (count_ff <= QUEUE_ROOM_MAX);
   assign head_entry = entries_ff[head_ff];

   assign rsp_if.valid          = (count_ff != '0);
   assign rsp_if.token          = head_entry.token;
   assign rsp_if.lexeme_length  = head_entry.length;
   assign rsp_if.constant_value = head_entry.value;
   assign rsp_if.last           = head_entry.last;

   assign pop      = rsp_if.valid && rsp_if.ready;
   assign head_in  = head_ff + QPTR_W'(pop);
   assign tail_in  = tail_ff + QPTR_W'(push.count);
   assign count_in = count_ff + QCNT_W'(push.count) - QCNT_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
      if (push.count != 2'd0) begin
         entries_ff[tail_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         entries_ff[tail_ff + QPTR_W'(1)] <= push.second;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (push.count != 2'd0) |-> (count_ff <= QUEUE_ROOM_MAX))
      else $error("request results pushed without room");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("result queue count out of range");

   a_push_code: assert property (@(posedge clock) disable iff (reset)
      push.count != 2'd3)
      else $error("more than two results from one request");

endmodule

@@ hw/rtl/table_driven_token_scanner.sv @@
// Token scanner: takes one source byte (or the end-of-input mark) per request and returns
// zero, one or two token results, each with its lexeme length (saturating at MAX_LEXEME)
// and, for constants, the decimal value saturating at 2^31-1. A request is taken every
// cycle while the result queue has room; it passes the input register, then the result
// queue, on its way to the result port. A request whose byte closes an identifier or
// constant and is itself a one-byte token yields two results, which leave one per cycle
// while the consumer is ready, so the result port sets the sustained rate. The four-entry
// result queue takes new requests while earlier results wait on the consumer; requests
// stall only when fewer than two queue entries are free.
module table_driven_token_scanner (
   input logic        clock,
   input logic        reset,
   tdts_req_if.sink   req_if,
   tdts_rsp_if.source rsp_if
);
   import tdts_pkg::*;

   push_type push;
   logic     room;

   tdts_lexer u_lexer (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .push   (push),
      .room   (room)
   );

   tdts_result_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .room   (room),
      .rsp_if (rsp_if)
   );

endmodule

@@ test/tb_top.sv @@
module tb_top;
   import tdts_pkg::*;

   localparam int RANDOM_ITEMS = 950;
   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_CYCLES = 8;

   typedef struct {
      logic [CH_W-1:0]  ch;
      logic             eoi;
      bit               typed;
      token_type        tok;
      logic [LEN_W-1:0] len;
   } stim_row_type;

   typedef enum {RX_OPEN, RX_COIN, RX_CHOKE, RX_CADENCE} rx_mode_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   tdts_req_if req_if ();
   tdts_rsp_if rsp_if ();

   table_driven_token_scanner dut (
      .clock (clock),
      .reset (reset),
      .req_if(req_if),
      .rsp_if(rsp_if)
   );

   always #5 clock = ~clock;

   // scanner state as the predictor sees it
   dfa_type          scan_mode = ST_START;
   logic [LEN_W-1:0] scan_len = '0;
   logic [VAL_W-1:0] scan_value = '0;
   result_type       step_out [2];
   int               step_count;

   result_type pending_tokens [$];

   int error_count = 0;
   int tokens_checked = 0;
   int bytes_sent = 0;
   int two_token_steps = 0;
   int long_lexemes = 0;
   int capped_values = 0;
   int burst_left = 0;
   int cycle_count = 0;

   function automatic class_type byte_class(input logic [CH_W-1:0] c, input logic eoi);
      if (eoi) return CLS_END;
      if ((c >= "A" && c <= "Z") || (c >= "a" && c <= "z")) return CLS_LETTER;
      if (c >= "0" && c <= "9") return CLS_DIGIT;
      case (c)
         "+": return CLS_PLUS;
         "-": return CLS_MINUS;
         "(": return CLS_LPAREN;
         ")": return CLS_RPAREN;
         ",": return CLS_COMMA;
         ";": return CLS_SEMICOLON;
         ":": return CLS_COLON;
         "=": return CLS_EQUAL;
         "*": return CLS_TIMES;
         "/": return CLS_DIVIDE;
         8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D: return CLS_BLANK;
         default: return CLS_OTHER;
      endcase
   endfunction

   function automatic void close_token(input token_type tok);
      step_out[step_count] = '{token: tok, length: scan_len,
                               value: (tok == TOK_CONST) ? scan_value : '0, last: 1'b0};
      step_count++;
      scan_mode = ST_START;
      scan_len = '0;
      scan_value = '0;
   endfunction

   function automatic void scan_char(input logic [CH_W-1:0] c, input logic eoi);
      class_type        cls;
      logic [3:0]       digit;
      logic [VAL_W+3:0] grown;
      bit               closed;
      cls = byte_class(c, eoi);
      digit = c[3:0];
      step_count = 0;
      closed = (scan_mode == ST_IDENT && cls != CLS_LETTER && cls != CLS_DIGIT) ||
               (scan_mode == ST_CONST && cls != CLS_DIGIT);
      if (closed) begin
         if (scan_mode == ST_IDENT) close_token(TOK_IDENT);
         else close_token(TOK_CONST);
      end
      // drop a blank that closed a lexeme; any other closing byte restarts from the start state
      if (!(closed && cls == CLS_BLANK)) begin
         if (cls != CLS_BLANK && scan_len < MAX_LEXEME) scan_len++;
         case (scan_mode)
            ST_START: begin
               case (cls)
                  CLS_LETTER: scan_mode = ST_IDENT;
                  CLS_DIGIT: begin
                     scan_mode = ST_CONST;
                     scan_value = VAL_W'(digit);
                  end
                  CLS_COLON: scan_mode = ST_COLON;
                  CLS_BLANK: ;
                  CLS_PLUS: close_token(TOK_PLUS);
                  CLS_MINUS: close_token(TOK_MINUS);
                  CLS_LPAREN: close_token(TOK_LPAREN);
                  CLS_RPAREN: close_token(TOK_RPAREN);
                  CLS_COMMA: close_token(TOK_COMMA);
                  CLS_SEMICOLON: close_token(TOK_SEMICOLON);
                  CLS_END: close_token(TOK_END);
                  CLS_TIMES: close_token(TOK_TIMES);
                  CLS_DIVIDE: close_token(TOK_DIVIDE);
                  default: close_token(TOK_ERROR);
               endcase
            end
            ST_CONST: begin
               grown = scan_value * 10 + digit;
               scan_value = (grown > VALUE_MAX) ? VALUE_MAX : grown[VAL_W-1:0];
            end
            ST_COLON: begin
               if (cls == CLS_EQUAL) close_token(TOK_ASSIGN);
               else close_token(TOK_ERROR);
            end
            default: ;
         endcase
      end
      if (step_count > 0) step_out[step_count-1].last = 1'b1;
   endfunction

   function automatic logic [CH_W-1:0] rand_letter();
      int k;
      k = $urandom_range(0, 51);
      return (k < 26) ? CH_W'(8'h41 + k) : CH_W'(8'h61 + k - 26);
   endfunction

   function automatic logic [CH_W-1:0] rand_digit();
      return CH_W'(8'h30 + $urandom_range(0, 9));
   endfunction

   task automatic send_byte(input logic [CH_W-1:0] c, input logic e, input bit typed = 1'b0,
                            input token_type tok = TOK_ERROR,
                            input logic [LEN_W-1:0] len = '0);
      if (burst_left == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150) : $urandom_range(1, 12);
      end
      req_if.valid <= 1'b1;
      req_if.ch <= c;
      req_if.end_of_input <= e;
      do @(posedge clock); while (!req_if.ready);
      burst_left--;
      bytes_sent++;
      scan_char(c, e);
      if (step_count == 2) two_token_steps++;
      if (typed) begin
         pending_tokens.push_back('{token: tok, length: len, value: '0, last: 1'b1});
      end else begin
         for (int k = 0; k < step_count; k++) pending_tokens.push_back(step_out[k]);
      end
   endtask

   task automatic send_char(input logic [CH_W-1:0] c);
      send_byte(c, 1'b0);
   endtask

   function automatic void check_field(input string name, input logic [VAL_W-1:0] got,
                                       input logic [VAL_W-1:0] want);
      if (got !== want) begin
         $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
         error_count++;
      end
   endfunction

   // result checker
   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_tokens.size() == 0) begin
            $display("%0t: unexpected token %0d len %0d value %0d last %0b", $time,
                     rsp_if.token, rsp_if.lexeme_length, rsp_if.constant_value, rsp_if.last);
            error_count++;
         end else begin
            want = pending_tokens.pop_front();
            tokens_checked++;
            if (want.length == MAX_LEXEME) long_lexemes++;
            if (want.token == TOK_CONST && want.value == VALUE_MAX) capped_values++;
            check_field("token", VAL_W'(rsp_if.token), VAL_W'(want.token));
            check_field("lexeme_length", VAL_W'(rsp_if.lexeme_length), VAL_W'(want.length));
            check_field("constant_value", rsp_if.constant_value, want.value);
            check_field("last", VAL_W'(rsp_if.last), VAL_W'(want.last));
         end
      end
   end

   // receiver stalls: switch at random between stall patterns
   rx_mode_type rx_mode = RX_OPEN;
   int          rx_left = 0;
   int          rx_phase = 0;

   always @(posedge clock) begin
      if (rx_left == 0) begin
         rx_mode = rx_mode_type'($urandom_range(0, 3));
         rx_left = $urandom_range(20, 200);
      end
      rx_left--;
      rx_phase++;
      case (rx_mode)
         RX_OPEN: rsp_if.ready <= 1'b1;
         RX_COIN: rsp_if.ready <= 1'($urandom_range(0, 1));
         RX_CHOKE: rsp_if.ready <= ($urandom_range(0, 4) == 0);
         default: rsp_if.ready <= ((rx_phase % 7) < 3);
      endcase
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d tokens outstanding", $time, pending_tokens.size());
         $display("CHECKS FAILED");
         $finish;
      end
   end

   logic [CH_W-1:0] op_bytes [8] = '{"+", "-", "(", ")", ",", ";", "*", "/"};
   logic [CH_W-1:0] blank_bytes [6] = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};

   initial begin
      stim_row_type directed [26];
      int           random_items;
      int           pick;
      int           len;
      req_if.valid = 1'b0;
      req_if.ch = '0;
      req_if.end_of_input = 1'b0;
      random_items = 0;
      directed = '{
         '{"A", 1'b1, 1'b1, TOK_END, 6'd1},          // ch ignored under end mark
         '{"+", 1'b0, 1'b1, TOK_PLUS, 6'd1},
         '{"-", 1'b0, 1'b1, TOK_MINUS, 6'd1},
         '{"(", 1'b0, 1'b1, TOK_LPAREN, 6'd1},
         '{")", 1'b0, 1'b1, TOK_RPAREN, 6'd1},
         '{",", 1'b0, 1'b1, TOK_COMMA, 6'd1},
         '{";", 1'b0, 1'b1, TOK_SEMICOLON, 6'd1},
         '{"*", 1'b0, 1'b1, TOK_TIMES, 6'd1},
         '{"/", 1'b0, 1'b1, TOK_DIVIDE, 6'd1},
         '{"=", 1'b0, 1'b1, TOK_ERROR, 6'd1},        // stray equal sign
         '{8'hFF, 1'b0, 1'b1, TOK_ERROR, 6'd1},
         '{8'h00, 1'b0, 1'b1, TOK_ERROR, 6'd1},
         '{8'h0B, 1'b0, 1'b0, TOK_ERROR, 6'd0},      // blank skipped at start
         '{":", 1'b0, 1'b0, TOK_ERROR, 6'd0},
         '{"=", 1'b0, 1'b1, TOK_ASSIGN, 6'd2},
         '{":", 1'b0, 1'b0, TOK_ERROR, 6'd0},
         '{"x", 1'b0, 1'b1, TOK_ERROR, 6'd2},        // colon without equal sign
         '{"Z", 1'b0, 1'b0, TOK_ERROR, 6'd0},
         '{"9", 1'b0, 1'b0, TOK_ERROR, 6'd0},
         '{";", 1'b0, 1'b0, TOK_ERROR, 6'd0},        // ident, then semicolon
         '{"0", 1'b0, 1'b0, TOK_ERROR, 6'd0},
         '{8'h09, 1'b0, 1'b0, TOK_ERROR, 6'd0},      // tab closes the constant
         '{"a", 1'b0, 1'b0, TOK_ERROR, 6'd0},
         '{"A", 1'b1, 1'b0, TOK_ERROR, 6'd0},        // ident, then end
         '{":", 1'b0, 1'b0, TOK_ERROR, 6'd0},
         '{"q", 1'b1, 1'b1, TOK_ERROR, 6'd2}         // colon closed by end mark
      };

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (directed[i])
         send_byte(directed[i].ch, directed[i].eoi, directed[i].typed, directed[i].tok,
                   directed[i].len);

      // mostly well-formed token streams, with noise and broken assignments mixed in
      while (random_items < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 99);
         if (pick < 25) begin
            len = ($urandom_range(0, 19) == 0) ? $urandom_range(30, 40) : $urandom_range(1, 6);
            send_char(rand_letter());
            for (int k = 1; k < len; k++)
               send_char(($urandom_range(0, 3) == 0) ? rand_digit() : rand_letter());
            random_items += len;
         end else if (pick < 45) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 14) : $urandom_range(1, 4);
            for (int k = 0; k < len; k++) send_char(rand_digit());
            random_items += len;
         end else if (pick < 65) begin
            send_char(op_bytes[$urandom_range(0, 7)]);
            random_items++;
         end else if (pick < 73) begin
            send_char(":");
            send_char("=");
            random_items += 2;
         end else if (pick < 77) begin
            send_char(":");
            send_char(CH_W'($urandom_range(0, 255)));
            random_items += 2;
         end else if (pick < 87) begin
            len = $urandom_range(1, 3);
            for (int k = 0; k < len; k++) send_char(blank_bytes[$urandom_range(0, 5)]);
            random_items += len;
         end else if (pick < 95) begin
            send_char(CH_W'($urandom_range(0, 255)));
            random_items++;
         end else begin
            send_byte(CH_W'($urandom_range(0, 255)), 1'b1);
            random_items++;
         end
      end
      // flush any open lexeme
      send_byte(8'h00, 1'b1);
      req_if.valid <= 1'b0;

      while (pending_tokens.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Scanned %0d bytes into %0d checked tokens, %0d bytes gave two tokens.",
               bytes_sent, tokens_checked, two_token_steps);
      $display("Saturated lexeme lengths: %0d, saturated constants: %0d.",
               long_lexemes, capped_values);
      if (error_count == 0 && pending_tokens.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

@@ files.f @@
hw/rtl/tdts_pkg.sv
hw/rtl/tdts_req_if.sv
hw/rtl/tdts_rsp_if.sv
hw/rtl/tdts_lexer.sv
hw/rtl/tdts_result_queue.sv
hw/rtl/table_driven_token_scanner.sv
test/tb_top.sv
